[rtl/bcoe_pkg.sv]
// Shared types and constants for the book cipher occurrence encoder.
// Used by the top level, the modulo unit and the testbench; depends on nothing.
package bcoe_pkg;

    localparam int KEY_CHARS  = 16384;
    localparam int KEY_WORDS  = 4096;
    localparam int KEY_ADDR_W = $clog2(KEY_CHARS);
    localparam int LEN_W      = KEY_ADDR_W + 1;
    localparam int WCNT_W     = $clog2(KEY_WORDS) + 1;
    localparam int ENTRY_W    = 9;
    localparam int RAND_W     = 15;
    localparam int DIV_W      = LEN_W;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_ENCODE = 2'd2;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_SPACE     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_NUL       = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [7:0] MAX_PICK_RESET = 8'd9;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        char_code;
        logic              ends_word;
        logic [RAND_W-1:0] rand_first;
        logic [RAND_W-1:0] rand_retry;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] word_index;
        logic [13:0] char_index;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] remainder;
    } t_mod_rsp;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_WALK = 3'b100
    } t_state;

endpackage

[rtl/book_cipher_occurrence_encoder_top.sv]
// Top level of the book cipher occurrence encoder: command sequencer and key walker.
// Depends on bcoe_pkg, bcoe_ram and bcoe_modulo.
//
// An item is taken when start is high and busy is low. Clear, key load, space, newline and
// NUL items leave busy low, so one can be given every cycle. An encode item runs a modulo
// step, then walks the stored key one character per cycle through the single read port of
// the key memory; when the first pick exceeds a nonzero match count a second modulo step
// and walk follow. Each result appears on o_result for exactly one cycle with o_strobe
// high, in the cycle after the work ends, and the receiver cannot hold it off. The key
// memory needs no clearing after reset.
module book_cipher_occurrence_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bcoe_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    output logic                o_strobe,
    output bcoe_pkg::t_out_item o_result
);

    localparam int AW = bcoe_pkg::KEY_ADDR_W;
    localparam int LW = bcoe_pkg::LEN_W;
    localparam int WW = bcoe_pkg::WCNT_W;
    localparam int DW = bcoe_pkg::DIV_W;

    bcoe_pkg::t_state    r_state;
    bcoe_pkg::t_state    n_state;
    logic [LW-1:0]       r_key_length;
    logic [LW-1:0]       n_key_length;
    logic [WW-1:0]       r_word_count;
    logic [WW-1:0]       n_word_count;
    logic [7:0]          r_max_first_pick;
    logic                r_second;
    logic                n_second;
    logic                r_vld;
    logic                n_vld;
    logic                r_strobe;
    logic                n_strobe;
    logic [7:0]          r_ch;
    logic [7:0]          n_ch;
    logic [bcoe_pkg::RAND_W-1:0] r_retry;
    logic [bcoe_pkg::RAND_W-1:0] n_retry;
    logic [LW-1:0]       r_pick;
    logic [LW-1:0]       n_pick;
    logic [LW-1:0]       r_issue;
    logic [LW-1:0]       n_issue;
    logic [LW-1:0]       r_count;
    logic [LW-1:0]       n_count;
    logic [WW-1:0]       r_w;
    logic [WW-1:0]       n_w;
    logic [AW-1:0]       r_c;
    logic [AW-1:0]       n_c;
    bcoe_pkg::t_out_item r_result;
    bcoe_pkg::t_out_item n_result;

    bcoe_pkg::t_mod_req  mod_req;
    bcoe_pkg::t_mod_rsp  mod_rsp;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [bcoe_pkg::ENTRY_W-1:0] ram_wdata;
    logic [bcoe_pkg::ENTRY_W-1:0] ram_rdata;
    logic                accept;
    logic                issuing;
    logic                match;
    logic [LW-1:0]       count_inc;
    logic [7:0]          low_ch;
    logic [7:0]          first_mod;

    bcoe_ram #(
        .WIDTH(bcoe_pkg::ENTRY_W),
        .DEPTH(bcoe_pkg::KEY_CHARS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    bcoe_modulo u_modulo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign accept    = start && (r_state == bcoe_pkg::S_IDLE);
    assign busy      = (r_state != bcoe_pkg::S_IDLE);
    assign issuing   = (r_issue < r_key_length);
    assign match     = r_vld && (ram_rdata[7:0] == r_ch);
    assign count_inc = r_count + LW'(match);
    assign first_mod = (r_max_first_pick == 8'd0) ? 8'd1 : r_max_first_pick;
    assign low_ch    = (i_item.char_code >= bcoe_pkg::CH_UPPER_A &&
                        i_item.char_code <= bcoe_pkg::CH_UPPER_Z) ?
                       i_item.char_code + bcoe_pkg::CASE_OFFSET : i_item.char_code;

    always_comb begin
        n_state      = r_state;
        n_key_length = r_key_length;
        n_word_count = r_word_count;
        n_second     = r_second;
        n_vld        = 1'b0;
        n_strobe     = 1'b0;
        n_ch         = r_ch;
        n_retry      = r_retry;
        n_pick       = r_pick;
        n_issue      = r_issue;
        n_count      = r_count;
        n_w          = r_w;
        n_c          = r_c;
        n_result     = '0;
        mod_req      = '0;
        ram_we       = 1'b0;
        ram_waddr    = r_key_length[AW-1:0];
        ram_wdata    = {i_item.ends_word, low_ch};
        unique case (r_state)
            bcoe_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.mode)
                        bcoe_pkg::MODE_CLEAR: begin
                            n_key_length    = '0;
                            n_word_count    = '0;
                            n_strobe        = 1'b1;
                            n_result.status = bcoe_pkg::ST_CLEARED;
                        end
                        bcoe_pkg::MODE_LOAD: begin
                            n_strobe = 1'b1;
                            if (r_key_length >= LW'(bcoe_pkg::KEY_CHARS) ||
                                r_word_count >= WW'(bcoe_pkg::KEY_WORDS)) begin
                                n_result.status = bcoe_pkg::ST_FULL;
                            end else begin
                                ram_we          = 1'b1;
                                n_key_length    = r_key_length + 1'b1;
                                n_word_count    = r_word_count + WW'(i_item.ends_word);
                                n_result.status = bcoe_pkg::ST_STORED;
                            end
                        end
                        bcoe_pkg::MODE_ENCODE: begin
                            if (i_item.char_code == bcoe_pkg::CH_SPACE ||
                                i_item.char_code == bcoe_pkg::CH_NEWLINE) begin
                                n_strobe        = 1'b1;
                                n_result.status = bcoe_pkg::ST_SPACE;
                            end else if (i_item.char_code == bcoe_pkg::CH_NUL) begin
                                n_strobe        = 1'b1;
                                n_result.status = bcoe_pkg::ST_NUL;
                            end else begin
                                n_ch             = i_item.char_code;
                                n_retry          = i_item.rand_retry;
                                n_second         = 1'b0;
                                mod_req.start    = 1'b1;
                                mod_req.dividend = DW'(i_item.rand_first);
                                mod_req.divisor  = DW'(first_mod);
                                n_state          = bcoe_pkg::S_MOD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bcoe_pkg::S_MOD: begin
                if (mod_rsp.done) begin
                    n_pick  = LW'(mod_rsp.remainder) + 1'b1;
                    n_issue = '0;
                    n_count = '0;
                    n_w     = '0;
                    n_c     = '0;
                    n_state = bcoe_pkg::S_WALK;
                end
            end
            bcoe_pkg::S_WALK: begin
                n_vld = issuing;
                if (issuing) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_vld) begin
                    if (match && count_inc == r_pick) begin
                        n_vld               = 1'b0;
                        n_strobe            = 1'b1;
                        n_result.status     = bcoe_pkg::ST_FOUND;
                        n_result.word_index = r_w[11:0];
                        n_result.char_index = r_c;
                        n_state             = bcoe_pkg::S_IDLE;
                    end else begin
                        n_count = count_inc;
                        if (ram_rdata[8]) begin
                            n_w = r_w + 1'b1;
                            n_c = '0;
                        end else begin
                            n_c = r_c + 1'b1;
                        end
                    end
                end else if (!issuing) begin
                    if (r_second || r_count == '0) begin
                        n_strobe        = 1'b1;
                        n_result.status = bcoe_pkg::ST_NOT_FOUND;
                        n_state         = bcoe_pkg::S_IDLE;
                    end else begin
                        n_second         = 1'b1;
                        mod_req.start    = 1'b1;
                        mod_req.dividend = DW'(r_retry);
                        mod_req.divisor  = DW'(r_count);
                        n_state          = bcoe_pkg::S_MOD;
                    end
                end
            end
            default: begin
                n_state = bcoe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= bcoe_pkg::S_IDLE;
            r_key_length     <= '0;
            r_word_count     <= '0;
            r_max_first_pick <= bcoe_pkg::MAX_PICK_RESET;
            r_second         <= 1'b0;
            r_vld            <= 1'b0;
            r_strobe         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_key_length <= n_key_length;
            r_word_count <= n_word_count;
            r_second     <= n_second;
            r_vld        <= n_vld;
            r_strobe     <= n_strobe;
            if (i_cfg_we) begin
                r_max_first_pick <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_retry  <= n_retry;
        r_pick   <= n_pick;
        r_issue  <= n_issue;
        r_count  <= n_count;
        r_w      <= n_w;
        r_c      <= n_c;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[rtl/bcoe_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; no package needed.
module bcoe_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bcoe_modulo.sv]
// Iterative restoring modulo unit, one dividend bit per cycle.
// Depends on bcoe_pkg for widths and the request and response structs.
module bcoe_modulo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcoe_pkg::t_mod_req  i_req,
    output bcoe_pkg::t_mod_rsp  o_rsp
);

    localparam int CNT_W = $clog2(bcoe_pkg::DIV_W);

    logic                         r_run;
    logic                         n_run;
    logic                         r_done;
    logic                         n_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [CNT_W-1:0]             n_cnt;
    logic [bcoe_pkg::DIV_W:0]     r_rem;
    logic [bcoe_pkg::DIV_W:0]     n_rem;
    logic [bcoe_pkg::DIV_W-1:0]   r_dvd;
    logic [bcoe_pkg::DIV_W-1:0]   n_dvd;
    logic [bcoe_pkg::DIV_W-1:0]   r_dvs;
    logic [bcoe_pkg::DIV_W-1:0]   n_dvs;
    logic [bcoe_pkg::DIV_W:0]     shifted;

    always_comb begin
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        shifted = {r_rem[bcoe_pkg::DIV_W-1:0], r_dvd[bcoe_pkg::DIV_W-1]};
        if (i_req.start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_dvd = i_req.dividend;
            n_dvs = i_req.divisor;
        end else if (r_run) begin
            n_dvd = {r_dvd[bcoe_pkg::DIV_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = shifted - {1'b0, r_dvs};
            end else begin
                n_rem = shifted;
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(bcoe_pkg::DIV_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[bcoe_pkg::DIV_W-1:0];

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for book_cipher_occurrence_encoder_top: a queue-fed driver, a
// result monitor and an in-bench predictor of the key store and occurrence search.
// Depends on bcoe_pkg and the RTL of the block.
module tb_top;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        bcoe_pkg::t_in_item item;
        logic [2:0]         gap;
    } t_pending;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    bcoe_pkg::t_in_item  i_item = '0;
    logic                i_cfg_we = 1'b0;
    logic [7:0]          i_cfg_wdata = '0;
    logic                o_strobe;
    bcoe_pkg::t_out_item o_result;

    t_pending            pending_items[$];
    bcoe_pkg::t_out_item expected_codes[$];
    logic                item_taken = 1'b0;
    int                  gap_left = 0;
    int                  gap_max = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;

    logic [8:0] key_mem [bcoe_pkg::KEY_CHARS];
    int         key_len = 0;
    int         word_cnt = 0;
    logic [7:0] max_pick = bcoe_pkg::MAX_PICK_RESET;

    book_cipher_occurrence_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int walk_key(input logic [7:0] ch, input int pick, output bit hit,
                                    output int wi, output int ci);
        int count;
        int w;
        int c;
        int p;
        count = 0;
        w = 0;
        c = 0;
        hit = 1'b0;
        wi = 0;
        ci = 0;
        for (p = 0; p < key_len; p++) begin
            if (key_mem[p][7:0] == ch) begin
                count++;
                if (count == pick) begin
                    hit = 1'b1;
                    wi = w;
                    ci = c;
                    return count;
                end
            end
            if (key_mem[p][8]) begin
                w++;
                c = 0;
            end else begin
                c++;
            end
        end
        return count;
    endfunction

    function automatic bit predict_cipher(input bcoe_pkg::t_in_item it,
                                          output bcoe_pkg::t_out_item res);
        logic [7:0] ch;
        int modulus;
        int pick;
        int total;
        int wi;
        int ci;
        bit hit;
        res = '0;
        ch = it.char_code;
        wi = 0;
        ci = 0;
        case (it.mode)
            bcoe_pkg::MODE_CLEAR: begin
                key_len = 0;
                word_cnt = 0;
                res.status = bcoe_pkg::ST_CLEARED;
            end
            bcoe_pkg::MODE_LOAD: begin
                if (key_len >= bcoe_pkg::KEY_CHARS || word_cnt >= bcoe_pkg::KEY_WORDS) begin
                    res.status = bcoe_pkg::ST_FULL;
                end else begin
                    if (ch >= bcoe_pkg::CH_UPPER_A && ch <= bcoe_pkg::CH_UPPER_Z)
                        ch = ch + bcoe_pkg::CASE_OFFSET;
                    key_mem[key_len] = {it.ends_word, ch};
                    key_len++;
                    if (it.ends_word)
                        word_cnt++;
                    res.status = bcoe_pkg::ST_STORED;
                end
            end
            bcoe_pkg::MODE_ENCODE: begin
                if (ch == bcoe_pkg::CH_SPACE || ch == bcoe_pkg::CH_NEWLINE) begin
                    res.status = bcoe_pkg::ST_SPACE;
                end else if (ch == bcoe_pkg::CH_NUL) begin
                    res.status = bcoe_pkg::ST_NUL;
                end else begin
                    modulus = (max_pick == 0) ? 1 : int'(max_pick);
                    pick = int'(it.rand_first) % modulus + 1;
                    total = walk_key(ch, pick, hit, wi, ci);
                    if (!hit && total == 0) begin
                        res.status = bcoe_pkg::ST_NOT_FOUND;
                    end else begin
                        if (!hit) begin
                            pick = int'(it.rand_retry) % total + 1;
                            void'(walk_key(ch, pick, hit, wi, ci));
                        end
                        res.status = bcoe_pkg::ST_FOUND;
                        res.word_index = wi[11:0];
                        res.char_index = ci[13:0];
                    end
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic add_cmd(input logic [1:0] m, input logic [7:0] ch, input logic ends,
                           input int r1, input int r2);
        t_pending p;
        p.item.mode = m;
        p.item.char_code = ch;
        p.item.ends_word = ends;
        p.item.rand_first = r1[bcoe_pkg::RAND_W-1:0];
        p.item.rand_retry = r2[bcoe_pkg::RAND_W-1:0];
        p.gap = 3'($urandom_range(0, gap_max));
        pending_items.push_back(p);
    endtask

    task automatic add_load(input logic [7:0] ch, input logic ends);
        add_cmd(bcoe_pkg::MODE_LOAD, ch, ends, $urandom_range(0, 32767),
                $urandom_range(0, 32767));
    endtask

    task automatic add_encode(input logic [7:0] ch, input int r1, input int r2);
        add_cmd(bcoe_pkg::MODE_ENCODE, ch, 1'($urandom_range(0, 1)), r1, r2);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_items.size() != 0 || start || expected_codes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_pick(input logic [7:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        max_pick = v;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !item_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items[0].item;
                gap_left <= int'(pending_items[0].gap);
                pending_items.delete(0);
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        bcoe_pkg::t_out_item want;
        bcoe_pkg::t_out_item next_code;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            if (o_strobe) begin
                if (expected_codes.size() == 0) begin
                    flag_error($sformatf("unexpected result: status %0d word %0d char %0d",
                        o_result.status, o_result.word_index, o_result.char_index));
                end else begin
                    want = expected_codes.pop_front();
                    if (o_result.status !== want.status
                            || o_result.word_index !== want.word_index
                            || o_result.char_index !== want.char_index)
                        flag_error($sformatf(
                            "expected status %0d word %0d char %0d, got %0d %0d %0d",
                            want.status, want.word_index, want.char_index,
                            o_result.status, o_result.word_index, o_result.char_index));
                end
            end
            item_taken <= start && !busy;
            if (start && !busy) begin
                if (predict_cipher(i_item, next_code))
                    expected_codes.push_back(next_code);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int klen;
        int alpha;
        int sel;
        logic [7:0] base;
        logic [7:0] ch;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Short directed sequence on a two-word key, the second word left open until a later load ends it.
        gap_max = 6;
        add_encode("a", 0, 0);
        add_cmd(2'b11, 8'hFF, 1'b1, 32767, 32767);
        add_load("H", 1'b0);
        add_load("e", 1'b0);
        add_load("l", 1'b0);
        add_load("l", 1'b0);
        add_load("o", 1'b1);
        add_cmd(bcoe_pkg::MODE_LOAD, "w", 1'b0, 32767, 32767);
        add_load("o", 1'b0);
        add_load("r", 1'b0);
        add_load("l", 1'b0);
        add_load("d", 1'b0);
        add_encode("l", 0, 0);
        add_encode("l", 8, 32767);
        add_encode("d", 2, 5);
        add_encode("L", 0, 0);
        add_encode(bcoe_pkg::CH_SPACE, 3, 3);
        add_encode(bcoe_pkg::CH_NEWLINE, 3, 3);
        add_encode(bcoe_pkg::CH_NUL, 3, 3);
        add_encode(8'hFF, 0, 0);
        add_load(8'hFF, 1'b1);
        add_encode(8'hFF, 32767, 0);
        write_max_pick(8'd0);
        add_encode("o", 32767, 32767);
        write_max_pick(8'd255);
        add_encode("l", 254, 1);
        add_cmd(bcoe_pkg::MODE_CLEAR, 8'hFF, 1'b1, 32767, 32767);

        // Random phases: a fresh short key, then mostly lookups of its letters.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_max_pick(8'd0);
                1: write_max_pick(8'd255);
                2: write_max_pick(8'd1);
                default: write_max_pick(8'($urandom_range(0, 255)));
            endcase
            gap_max = (ph % 2) ? 6 : 0;
            add_cmd(bcoe_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), $urandom_range(0, 32767),
                    $urandom_range(0, 32767));
            base = CH_LOWER_A + 8'($urandom_range(0, 20));
            alpha = $urandom_range(1, 5);
            klen = $urandom_range(1, 16);
            for (int k = 0; k < klen; k++) begin
                ch = base + 8'($urandom_range(0, alpha - 1));
                if ($urandom_range(0, 3) == 0)
                    ch = ch - bcoe_pkg::CASE_OFFSET;
                if ($urandom_range(0, 9) == 0)
                    ch = 8'($urandom_range(1, 255));
                add_load(ch, $urandom_range(0, 2) == 0);
            end
            for (int e = 0; e < 10; e++) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0: add_encode(8'($urandom_range(0, 255)), $urandom_range(0, 32767),
                                  $urandom_range(0, 32767));
                    1: begin
                        case ($urandom_range(0, 2))
                            0: ch = bcoe_pkg::CH_SPACE;
                            1: ch = bcoe_pkg::CH_NEWLINE;
                            default: ch = bcoe_pkg::CH_NUL;
                        endcase
                        add_encode(ch, $urandom_range(0, 32767), $urandom_range(0, 32767));
                    end
                    2: begin
                        if ($urandom_range(0, 1))
                            add_cmd(2'b11, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), $urandom_range(0, 32767),
                                    $urandom_range(0, 32767));
                        else
                            add_load(base + 8'($urandom_range(0, alpha - 1)),
                                     1'($urandom_range(0, 1)));
                    end
                    default: add_encode(base + 8'($urandom_range(0, alpha)),
                                        $urandom_range(0, 32767), $urandom_range(0, 32767));
                endcase
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
